// ===== rtl/sxl_pkg.sv =====
// Shared types and constants for the s-expression token lexer.
`default_nettype none
package sxl_pkg;

	// Length and depth limits
	localparam logic [31:0] MAX_TOKEN_LEN = 32'd65535;
	localparam logic [15:0] MAX_DEPTH     = 16'd255;
	localparam logic [15:0] LEN_CAP = (MAX_TOKEN_LEN < 32'd65535) ? MAX_TOKEN_LEN[15:0]
		: 16'hFFFF;
	localparam logic [7:0] DEPTH_CAP = (MAX_DEPTH < 16'd255) ? MAX_DEPTH[7:0] : 8'hFF;

	// Queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// Stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 96;

	// Character codes
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [2:0] {
		KIND_OPEN    = 3'd0,
		KIND_CLOSE   = 3'd1,
		KIND_INT     = 3'd2,
		KIND_SYM     = 3'd3,
		KIND_BAD_INT = 3'd4,
		KIND_END     = 3'd5,
		KIND_STRAY   = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_ATOM    = 2'd1,
		MODE_COMMENT = 2'd2
	} mode_t;

	// One result token
	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] int_value;
		logic [31:0]        token_start;
		logic [15:0]        token_length;
		logic [7:0]         nest_depth;
		logic               last_of_run;
	} res_t;

	// All results caused by one input byte (one or two)
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} bundle_t;

endpackage
`default_nettype wire

// ===== rtl/sexpr_token_lexer.sv =====
// A byte's result bundle is written into the bundle queue, then moved into the output register behind m_tvalid.
// The source takes one byte per cycle while the bundle queue is not full; the output port moves
// one result per cycle while m_tready is high, so a byte that yields an atom and a paren holds it for both.
// The bundle queue absorbs such bursts and downstream stalls.
// Reset: arst_n clears lexer state, depth, byte position, queue and output valid.
`default_nettype none
module sexpr_token_lexer
	import sxl_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] byte_value
	input  wire logic                   s_tlast,   // end_of_input
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [2:0] token_kind, [34:3] int_value, [66:35] token_start,
	// [82:67] token_length, [90:83] nest_depth, [95:91] zero
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tlast    // last_of_run
);

	logic    q_push, q_pop, q_full, q_empty;
	bundle_t q_wr, q_rd;

	sxl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_wr)
	);

	sxl_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data(q_wr),
		.pop    (q_pop),
		.rd_data(q_rd),
		.full   (q_full),
		.empty  (q_empty)
	);

	sxl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_rd),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

`ifndef SYNTHESIS
	// Queue never overflows or underflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("bundle queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("bundle queue underflow");
	// A two-result bundle ends only on its second result
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_wr.two) |-> (q_wr.r1.last_of_run && !q_wr.r0.last_of_run))
		else $error("bad last marking in result pair");
	// A non-final result is always followed by its partner
	a_pair_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("second result of pair missing");
`endif

endmodule
`default_nettype wire

// ===== rtl/sxl_front.sv =====
// Front end: classifies input bytes, keeps lexer state, builds result bundles.
`default_nettype none
module sxl_front
	import sxl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] byte_value
	input  wire logic                  s_tlast,   // end_of_input
	input  wire logic                  q_full,
	output logic                       q_push,
	output bundle_t                    q_data
);

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_LF) || (c == CH_COMMA) || (c == CH_TAB) ||
			(c == CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	mode_t       mode_q, mode_d;
	logic [31:0] atom_start_q, atom_start_d;
	logic [15:0] atom_len_q, atom_len_d;
	logic [31:0] acc_q, acc_d;
	logic        is_num_q, is_num_d;
	logic        malformed_q, malformed_d;
	logic [7:0]  depth_q, depth_d;
	logic [31:0] pos_q, pos_d;

	logic        accept;
	logic [7:0]  c;
	logic        c_paren;
	logic [31:0] acc_step;
	logic [7:0]  paren_depth;
	res_t        atom_res, paren_res, end_res;
	logic        any_res;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign c        = s_tdata[7:0];
	assign c_paren  = (c == CH_LPAREN) || (c == CH_RPAREN);

	// acc*10 + digit as shifts and adds
	assign acc_step = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, c[3:0]};

	// Token records that this byte may produce
	always_comb begin
		atom_res = '0;
		atom_res.token_start  = atom_start_q;
		atom_res.token_length = atom_len_q;
		atom_res.nest_depth   = depth_q;
		if (!is_num_q) begin
			atom_res.kind = KIND_SYM;
		end else if (malformed_q) begin
			atom_res.kind = KIND_BAD_INT;
		end else begin
			atom_res.kind      = KIND_INT;
			atom_res.int_value = acc_q;
		end

		paren_res = '0;
		paren_res.token_start  = pos_q;
		paren_res.token_length = 16'd1;
		paren_res.last_of_run  = 1'b1;
		if (c == CH_LPAREN) begin
			paren_depth    = (depth_q < DEPTH_CAP) ? depth_q + 8'd1 : depth_q;
			paren_res.kind = KIND_OPEN;
		end else if (depth_q == 8'd0) begin
			paren_depth    = 8'd0;
			paren_res.kind = KIND_STRAY;
		end else begin
			paren_depth    = depth_q - 8'd1;
			paren_res.kind = KIND_CLOSE;
		end
		paren_res.nest_depth = paren_depth;

		end_res = '0;
		end_res.kind        = KIND_END;
		end_res.token_start = pos_q;
		end_res.nest_depth  = depth_q;
		end_res.last_of_run = 1'b1;
	end

	// Next state
	always_comb begin
		mode_d       = mode_q;
		atom_start_d = atom_start_q;
		atom_len_d   = atom_len_q;
		acc_d        = acc_q;
		is_num_d     = is_num_q;
		malformed_d  = malformed_q;
		depth_d      = depth_q;
		pos_d        = pos_q + 32'd1;
		if (s_tlast) begin
			mode_d       = MODE_IDLE;
			atom_start_d = '0;
			atom_len_d   = '0;
			acc_d        = '0;
			is_num_d     = 1'b0;
			malformed_d  = 1'b0;
			depth_d      = '0;
			pos_d        = '0;
		end else begin
			unique case (mode_q)
				MODE_COMMENT: begin
					if (c == CH_LF) mode_d = MODE_IDLE;
				end
				MODE_ATOM: begin
					if (is_space(c)) begin
						mode_d = MODE_IDLE;
					end else if (c_paren) begin
						mode_d  = MODE_IDLE;
						depth_d = paren_depth;
					end else begin
						if (atom_len_q < LEN_CAP) atom_len_d = atom_len_q + 16'd1;
						if (is_digit(c)) acc_d = acc_step;
						else malformed_d = 1'b1;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					if (is_space(c)) begin
						mode_d = MODE_IDLE;
					end else if (c == CH_SEMI) begin
						mode_d = MODE_COMMENT;
					end else if (c_paren) begin
						depth_d = paren_depth;
					end else begin
						mode_d       = MODE_ATOM;
						atom_start_d = pos_q;
						atom_len_d   = 16'd1;
						malformed_d  = 1'b0;
						is_num_d     = is_digit(c);
						acc_d        = is_digit(c) ? {28'd0, c[3:0]} : 32'd0;
					end
				end
			endcase
		end
	end

	// Result bundle for this byte
	always_comb begin
		q_data  = '0;
		any_res = 1'b0;
		if (s_tlast) begin
			any_res = 1'b1;
			if (mode_q == MODE_ATOM) begin
				q_data.r0  = atom_res;
				q_data.r1  = end_res;
				q_data.two = 1'b1;
			end else begin
				q_data.r0 = end_res;
			end
		end else begin
			unique case (mode_q)
				MODE_COMMENT: begin
					any_res = 1'b0;
				end
				MODE_ATOM: begin
					if (is_space(c)) begin
						any_res              = 1'b1;
						q_data.r0            = atom_res;
						q_data.r0.last_of_run = 1'b1;
					end else if (c_paren) begin
						any_res    = 1'b1;
						q_data.r0  = atom_res;
						q_data.r1  = paren_res;
						q_data.two = 1'b1;
					end
				end
				default: begin
					if (c_paren && !is_space(c)) begin
						any_res   = 1'b1;
						q_data.r0 = paren_res;
					end
				end
			endcase
		end
	end

	assign q_push = accept && any_res;

	// Lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			atom_start_q <= '0;
			atom_len_q   <= '0;
			acc_q        <= '0;
			is_num_q     <= 1'b0;
			malformed_q  <= 1'b0;
			depth_q      <= '0;
			pos_q        <= '0;
		end else if (accept) begin
			mode_q       <= mode_d;
			atom_start_q <= atom_start_d;
			atom_len_q   <= atom_len_d;
			acc_q        <= acc_d;
			is_num_q     <= is_num_d;
			malformed_q  <= malformed_d;
			depth_q      <= depth_d;
			pos_q        <= pos_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sxl_fifo.sv =====
// Short queue of result bundles between front and back.
`default_nettype none
module sxl_fifo
	import sxl_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  bundle_t      wr_data,
	input  wire logic    pop,
	output bundle_t      rd_data,
	output logic         full,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sxl_back.sv =====
// Back end: splits bundles into single results and drives the output register.
`default_nettype none
module sxl_back
	import sxl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  bundle_t                     q_data,
	input  wire logic                   q_empty,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // kind, int_value, start, length, depth
	output logic                        m_tlast   // last_of_run
);

	res_t out_q, sec_q;
	logic out_vld_q, sec_vld_q;
	logic out_free;

	assign out_free = !out_vld_q || m_tready;
	assign q_pop    = out_free && !sec_vld_q && !q_empty;

	// Output register and pending second result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sec_vld_q <= 1'b0;
		end else if (out_free) begin
			if (sec_vld_q) begin
				out_vld_q <= 1'b1;
				sec_vld_q <= 1'b0;
			end else if (!q_empty) begin
				out_vld_q <= 1'b1;
				sec_vld_q <= q_data.two;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (sec_vld_q) begin
				out_q <= sec_q;
			end else if (!q_empty) begin
				out_q <= q_data.r0;
				sec_q <= q_data.r1;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_q.last_of_run;
	assign m_tdata  = {5'd0, out_q.nest_depth, out_q.token_length, out_q.token_start,
		out_q.int_value, out_q.kind};

endmodule
`default_nettype wire

// ===== bench/sexpr_token_lexer_check.sv =====
`timescale 1ns / 100ps
// Token checker for the s-expression lexer: predicts tokens from input transfers and compares.
module sexpr_token_lexer_check
	import sxl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] byte_value
	input  logic                   s_tlast,   // end_of_input
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	// [2:0] token_kind, [34:3] int_value, [66:35] token_start,
	// [82:67] token_length, [90:83] nest_depth, [95:91] zero
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   m_tlast,   // last_of_run
	output int                     fails,
	output int                     pending,
	output int                     tokens_checked
);

	// Shadow lexer state
	mode_t       scan;
	logic [31:0] atom_pos;
	logic [15:0] atom_len;
	logic [31:0] acc;
	logic        is_num;
	logic        malformed;
	logic [7:0]  depth;
	logic [31:0] byte_pos;

	// Tokens predicted but not yet seen on the output
	res_t tokens_due[$];

	function automatic res_t token(input kind_t k, input logic [31:0] v,
		input logic [31:0] at, input logic [15:0] n, input logic [7:0] d);
		res_t t;
		t.kind         = k;
		t.int_value    = v;
		t.token_start  = at;
		t.token_length = n;
		t.nest_depth   = d;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_LF || c == CH_COMMA || c == CH_TAB || c == CH_CR;
	endfunction

	function automatic bit is_numeral(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// Token for the atom now pending
	function res_t atom_token();
		if (!is_num)
			return token(KIND_SYM, '0, atom_pos, atom_len, depth);
		else if (malformed)
			return token(KIND_BAD_INT, '0, atom_pos, atom_len, depth);
		else
			return token(KIND_INT, acc, atom_pos, atom_len, depth);
	endfunction

	// Token for a paren at the current position; updates depth
	function res_t bracket_token(input logic [7:0] c);
		if (c == CH_LPAREN) begin
			if (depth < DEPTH_CAP)
				depth++;
			return token(KIND_OPEN, '0, byte_pos, 16'd1, depth);
		end else if (depth == 8'd0) begin
			return token(KIND_STRAY, '0, byte_pos, 16'd1, 8'd0);
		end else begin
			depth--;
			return token(KIND_CLOSE, '0, byte_pos, 16'd1, depth);
		end
	endfunction

	task clear_state();
		scan      = MODE_IDLE;
		atom_pos  = '0;
		atom_len  = '0;
		acc       = '0;
		is_num    = 1'b0;
		malformed = 1'b0;
		depth     = '0;
		byte_pos  = '0;
	endtask

	// Advance the shadow lexer by one input transfer and queue its tokens
	task predict_byte(input logic [7:0] c, input logic eoi);
		res_t out [2];
		int   n;
		bit   paren;
		n = 0;
		paren = (c == CH_LPAREN || c == CH_RPAREN);
		if (eoi) begin
			if (scan == MODE_ATOM) begin
				out[n] = atom_token();
				n++;
			end
			out[n] = token(KIND_END, '0, byte_pos, 16'd0, depth);
			n++;
			clear_state();
		end else begin
			case (scan)
				MODE_COMMENT: begin
					if (c == CH_LF)
						scan = MODE_IDLE;
				end
				MODE_ATOM: begin
					if (is_blank(c) || paren) begin
						out[n] = atom_token();
						n++;
						scan = MODE_IDLE;
						if (paren) begin
							out[n] = bracket_token(c);
							n++;
						end
					end else begin
						if (atom_len < LEN_CAP)
							atom_len++;
						if (is_numeral(c))
							acc = acc * 32'd10 + 32'(c - CH_ZERO);
						else
							malformed = 1'b1;
					end
				end
				default: begin
					scan = MODE_IDLE;
					if (c == CH_SEMI) begin
						scan = MODE_COMMENT;
					end else if (paren) begin
						out[n] = bracket_token(c);
						n++;
					end else if (!is_blank(c)) begin
						scan      = MODE_ATOM;
						atom_pos  = byte_pos;
						atom_len  = 16'd1;
						malformed = 1'b0;
						is_num    = is_numeral(c);
						acc       = is_num ? 32'(c - CH_ZERO) : 32'd0;
					end
				end
			endcase
			byte_pos++;
		end
		if (n > 0)
			out[n-1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			tokens_due.push_back(out[i]);
	endtask

	task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	initial begin
		fails = 0;
		tokens_checked = 0;
		pending = 0;
		clear_state();
	end

	// Predict on input transfers, compare on output transfers
	always @(posedge clk) begin : watch
		res_t want;
		if (!arst_n) begin
			clear_state();
			tokens_due.delete();
		end else begin
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (tokens_due.size() == 0) begin
					fails++;
					$display("%0t: unexpected token, expected none, actual tdata %0h tlast %0b",
						$time, m_tdata, m_tlast);
				end else begin
					want = tokens_due.pop_front();
					tokens_checked++;
					check_field("token_kind", 32'(want.kind), 32'(m_tdata[2:0]));
					check_field("int_value", want.int_value, m_tdata[34:3]);
					check_field("token_start", want.token_start, m_tdata[66:35]);
					check_field("token_length", 32'(want.token_length), 32'(m_tdata[82:67]));
					check_field("nest_depth", 32'(want.nest_depth), 32'(m_tdata[90:83]));
					check_field("tdata pad", 32'd0, 32'(m_tdata[95:91]));
					check_field("last_of_run", 32'(want.last_of_run), 32'(m_tlast));
				end
			end
		end
		pending <= tokens_due.size();
	end

endmodule

// ===== bench/sexpr_token_lexer_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the s-expression lexer: reset, clock, byte stimulus, output stalls, verdict.
module sexpr_token_lexer_test
	import sxl_pkg::*;
();

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] byte_value
	logic                   s_tlast  = 1'b0; // end_of_input
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [2:0] token_kind, [34:3] int_value, [66:35] token_start,
	// [82:67] token_length, [90:83] nest_depth, [95:91] zero
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;         // last_of_run

	int   fails;
	int   pending;
	int   tokens_checked;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   bytes_sent    = 0;
	int   texts_ended   = 0;
	logic hold_req      = 1'b0;

	sexpr_token_lexer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	sexpr_token_lexer_check chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.fails          (fails),
		.pending        (pending),
		.tokens_checked (tokens_checked)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#2000000;
		$display("[sexpr_token_lexer] ERROR");
		$finish;
	end

	// Output side: random backpressure, plus one long hold-off on request
	initial begin : sink
		bit held_once = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held_once) begin
				held_once = 1'b1;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic bit is_delim(input logic [7:0] b);
		return b == CH_SPACE || b == CH_LF || b == CH_COMMA || b == CH_TAB || b == CH_CR
			|| b == CH_LPAREN || b == CH_RPAREN;
	endfunction

	// Any byte that continues an atom
	function automatic logic [7:0] atom_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (is_delim(b));
		return b;
	endfunction

	function automatic logic [7:0] nondigit_byte();
		logic [7:0] b;
		do b = atom_byte(); while (b >= CH_ZERO && b <= CH_NINE);
		return b;
	endfunction

	function automatic logic [7:0] digit_byte();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] blank_byte();
		case ($urandom_range(4))
			0: return CH_SPACE;
			1: return CH_LF;
			2: return CH_COMMA;
			3: return CH_TAB;
			default: return CH_CR;
		endcase
	endfunction

	// One input transfer, with random idle cycles ahead of it
	task automatic send_item(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eoi;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if (eoi)
			texts_ended++;
	endtask

	task automatic send_text(input string t);
		for (int i = 0; i < t.len(); i++)
			send_item(t[i], 1'b0);
	endtask

	// Digits, optionally spoiled by one non-digit after the first
	task automatic send_number(input int digits, input bit spoil);
		int bad_at;
		bad_at = spoil ? $urandom_range(digits - 1, 1) : digits;
		for (int i = 0; i < digits; i++)
			send_item(i == bad_at ? nondigit_byte() : digit_byte(), 1'b0);
	endtask

	task automatic send_symbol(input int n);
		logic [7:0] head;
		do head = nondigit_byte(); while (head == CH_SEMI);
		send_item(head, 1'b0);
		for (int i = 1; i < n; i++)
			send_item(atom_byte(), 1'b0);
	endtask

	// Whitespace or a paren that closes an atom
	task automatic send_delim();
		case ($urandom_range(3))
			0: send_item(CH_LPAREN, 1'b0);
			1: send_item(CH_RPAREN, 1'b0);
			default: send_item(blank_byte(), 1'b0);
		endcase
	endtask

	// One random construct; atoms are mostly terminated properly
	task automatic send_phrase();
		int  pick;
		bit  atom;
		pick = $urandom_range(99);
		atom = 1'b0;
		if (pick < 18) begin
			send_number($urandom_range(12, 1), 1'b0);
			atom = 1'b1;
		end else if (pick < 26) begin
			send_number($urandom_range(6, 2), 1'b1);
			atom = 1'b1;
		end else if (pick < 44) begin
			send_symbol($urandom_range(8, 1));
			atom = 1'b1;
		end else if (pick < 56) begin
			send_item(CH_LPAREN, 1'b0);
		end else if (pick < 68) begin
			send_item(CH_RPAREN, 1'b0);
		end else if (pick < 78) begin
			repeat ($urandom_range(3, 1)) send_item(blank_byte(), 1'b0);
		end else if (pick < 84) begin
			send_item(CH_SEMI, 1'b0);
			repeat ($urandom_range(6)) send_item(8'($urandom_range(255)), 1'b0);
			send_item(CH_LF, 1'b0);
		end else if (pick < 87) begin
			send_item(8'($urandom_range(255)), 1'b1);
		end else begin
			send_item(8'($urandom_range(255)), 1'b0);
		end
		if (atom && $urandom_range(4) != 0)
			send_delim();
	endtask

	task automatic send_random(input int count);
		int stop_at;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at)
			send_phrase();
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idling less than receiver
		send_idle_pct = 31;
		recv_idle_pct = 49;

		// Directed: parens, atom then paren, stray close, comment, bad integer,
		// semicolon and zero byte inside an atom, end inside comment and inside atom
		send_text("(a 42));x\n1x,a;");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("\t9\r(;c");
		send_item(8'hFF, 1'b1);
		send_text("z");
		send_item(8'h00, 1'b1);

		// Random text
		send_random(420);

		// Receiver idling less than sender; nesting past the depth cap
		send_idle_pct = 49;
		recv_idle_pct = 31;
		send_random(420);
		repeat (258) send_item(CH_LPAREN, 1'b0);
		repeat (260) send_item(CH_RPAREN, 1'b0);

		// No idling; fill the block while the receiver holds off
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req <= 1'b1;
		repeat (40) send_item($urandom_range(1) ? CH_LPAREN : CH_RPAREN, 1'b0);
		hold_req <= 1'b0;
		send_random(420);

		// Long number, value wraps many times
		for (int i = 0; i < 40; i++)
			send_item(digit_byte(), 1'b0);
		send_item(CH_SPACE, 1'b0);
		send_item(8'($urandom_range(255)), 1'b1);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d source bytes in %0d texts under three idle profiles, incl. deep nesting,",
			bytes_sent, texts_ended);
		$display("a 40-digit number and a 300-cycle output hold; %0d tokens compared.",
			tokens_checked);
		if (fails == 0 && pending == 0)
			$display("[sexpr_token_lexer] OK");
		else
			$display("[sexpr_token_lexer] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sxl_pkg.sv
rtl/sxl_front.sv
rtl/sxl_fifo.sv
rtl/sxl_back.sv
rtl/sexpr_token_lexer.sv
bench/sexpr_token_lexer_check.sv
bench/sexpr_token_lexer_test.sv
